### rtl/assert_macros.svh
// Assertion macros for the RTL of the yaw PID position controller.
// Depends on nothing; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("property violated");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("property violated");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/yppc_pkg.sv
// Package of the yaw PID position controller: widths, constants, register
// indices, stage structures and the symmetric clamp. Depends on nothing.
package yppc_pkg;

	// Field and datapath widths.
	localparam int ANG_W  = 15;
	localparam int ERR_W  = 16;
	localparam int DE_W   = 17;
	localparam int INT_W  = 32;
	localparam int GAIN_W = 18;
	localparam int LIM_W  = 14;
	localparam int OUT_W  = 16;
	localparam int FRAC_W = 16;

	// Product and sum widths: gains are widened by a zero sign bit.
	localparam int P_E_W  = GAIN_W + 1 + ERR_W;
	localparam int P_DE_W = GAIN_W + 1 + DE_W;
	localparam int P_I_W  = GAIN_W + 1 + INT_W;
	localparam int SUM_W  = P_I_W + 3;
	localparam int QUO_W  = SUM_W - FRAC_W;

	// Angle constants in degrees times 64.
	localparam logic signed [ERR_W-1:0] HALF_TURN = 16'sd11520;
	localparam logic signed [ERR_W-1:0] FULL_TURN = 16'sd23040;

	// Rounding offset for the Q16 result.
	localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(32768);

	// Output saturation bounds.
	localparam logic signed [QUO_W-1:0] OUT_MAX = QUO_W'(32767);
	localparam logic signed [QUO_W-1:0] OUT_MIN = -QUO_W'(32768);

	// Configuration port.
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int IDX_W  = 3;

	localparam logic [IDX_W-1:0] REG_GAIN_PROP  = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_INTEG = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_DERIV = 3'd2;
	localparam logic [IDX_W-1:0] REG_ERR_LIMIT  = 3'd3;
	localparam logic [IDX_W-1:0] REG_STEP_LIMIT = 3'd4;

	localparam logic [GAIN_W-1:0] RST_GAIN_PROP  = 18'd32768;
	localparam logic [GAIN_W-1:0] RST_GAIN_INTEG = 18'd118;
	localparam logic [GAIN_W-1:0] RST_GAIN_DERIV = 18'd3277;
	localparam logic [LIM_W-1:0]  RST_ERR_LIMIT  = 14'd5760;
	localparam logic [LIM_W-1:0]  RST_STEP_LIMIT = 14'd1920;

	// Configuration register set.
	typedef struct packed {
		logic [GAIN_W-1:0] gain_prop;
		logic [GAIN_W-1:0] gain_integ;
		logic [GAIN_W-1:0] gain_deriv;
		logic [LIM_W-1:0]  error_limit;
		logic [LIM_W-1:0]  integral_step_limit;
	} cfg_t;

	// Input register contents.
	typedef struct packed {
		logic                    valid;
		logic                    mode;
		logic signed [ANG_W-1:0] target;
		logic signed [ANG_W-1:0] measured;
	} in_stage_t;

	// Wrapped and clamped error, and the step added to the integral.
	typedef struct packed {
		logic                    valid;
		logic                    mode;
		logic signed [ERR_W-1:0] err;
		logic signed [ERR_W-1:0] step;
	} err_stage_t;

	// Operands of the three products.
	typedef struct packed {
		logic                    valid;
		logic signed [ERR_W-1:0] err;
		logic signed [DE_W-1:0]  de;
		logic signed [INT_W-1:0] integ;
	} pid_stage_t;

	// Registered products.
	typedef struct packed {
		logic                     valid;
		logic signed [P_E_W-1:0]  p_e;
		logic signed [P_DE_W-1:0] p_de;
		logic signed [P_I_W-1:0]  p_i;
	} prod_stage_t;

	// Clamp a signed error to plus or minus an unsigned limit.
	function automatic logic signed [ERR_W-1:0] clamp_sym(
		input logic signed [ERR_W-1:0] v,
		input logic [LIM_W-1:0] lim
	);
		logic signed [ERR_W:0] v_x;
		logic signed [ERR_W:0] l_x;
		logic signed [ERR_W:0] nl_x;
		logic signed [ERR_W-1:0] res;
		v_x  = {v[ERR_W-1], v};
		l_x  = $signed({{(ERR_W + 1 - LIM_W){1'b0}}, lim});
		nl_x = -l_x;
		if (v_x > l_x) begin
			res = l_x[ERR_W-1:0];
		end else if (v_x < nl_x) begin
			res = nl_x[ERR_W-1:0];
		end else begin
			res = v;
		end
		return res;
	endfunction

endpackage

### rtl/yaw_pid_position_controller_top.sv
// Yaw PID position controller: one transaction per clock cycle, unless stalled.
// A run transaction passes from acceptance through the input register, error
// stage, state stage and product stage into the output register.
// A stalled result freezes the whole pipeline and the input stalls with it.
// Reset clears all valid flags, the integral and previous error, and loads
// the configuration registers with their reset values.
`include "assert_macros.svh"

module yaw_pid_position_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [yppc_pkg::ADDR_W-1:0]         paddr,
	input  logic [yppc_pkg::DATA_W-1:0]         pwdata,
	output logic [yppc_pkg::DATA_W-1:0]         prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                position_mode,
	input  logic signed [yppc_pkg::ANG_W-1:0]   target_yaw,
	input  logic signed [yppc_pkg::ANG_W-1:0]   measured_yaw,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [yppc_pkg::OUT_W-1:0]   speed_command
);

	yppc_pkg::cfg_t        cfg;
	yppc_pkg::err_stage_t  s2;
	yppc_pkg::pid_stage_t  s3;
	logic                  adv;

	assign in_stall = !adv;

	// Configuration registers.
	yppc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Input register and error stage.
	yppc_err u_err (
		.clk           (clk),
		.arst_n        (arst_n),
		.adv           (adv),
		.in_valid      (in_valid),
		.position_mode (position_mode),
		.target_yaw    (target_yaw),
		.measured_yaw  (measured_yaw),
		.cfg           (cfg),
		.s2            (s2)
	);

	// Integral and previous-error state.
	yppc_integ u_integ (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.s2     (s2),
		.s3     (s3)
	);

	// Products, rounding and output register.
	yppc_mac u_mac (
		.clk           (clk),
		.arst_n        (arst_n),
		.s3            (s3),
		.cfg           (cfg),
		.out_stall     (out_stall),
		.adv           (adv),
		.out_valid     (out_valid),
		.speed_command (speed_command)
	);

	// A run transaction that leaves the error stage reaches the product operands.
	`ASSERT_NEXT(a_run_reaches_s3, clk, arst_n, adv && s2.valid && s2.mode, s3.valid)
	// A hold transaction or a bubble never produces product operands.
	`ASSERT_NEXT(a_hold_drops, clk, arst_n, adv && !(s2.valid && s2.mode), !s3.valid)
	// While frozen, pending product operands stay in place.
	`ASSERT_NEXT(a_freeze_holds, clk, arst_n, !adv && s3.valid, s3.valid)
	// The input only stalls behind a held result.
	`ASSERT_IMPLY(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall)

endmodule

### rtl/yppc_cfg.sv
// Configuration registers of the yaw PID controller behind an APB-style port.
// Depends on yppc_pkg.
module yppc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [yppc_pkg::ADDR_W-1:0]   paddr,
	input  logic [yppc_pkg::DATA_W-1:0]   pwdata,
	output logic [yppc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	output yppc_pkg::cfg_t                cfg
);

	yppc_pkg::cfg_t             cfg_q;
	logic [yppc_pkg::IDX_W-1:0] idx;
	logic                       wr_en;

	assign idx    = paddr[yppc_pkg::ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// Register writes; an address beyond the register list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_prop           <= yppc_pkg::RST_GAIN_PROP;
			cfg_q.gain_integ          <= yppc_pkg::RST_GAIN_INTEG;
			cfg_q.gain_deriv          <= yppc_pkg::RST_GAIN_DERIV;
			cfg_q.error_limit         <= yppc_pkg::RST_ERR_LIMIT;
			cfg_q.integral_step_limit <= yppc_pkg::RST_STEP_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				yppc_pkg::REG_GAIN_PROP: begin
					cfg_q.gain_prop <= pwdata[yppc_pkg::GAIN_W-1:0];
				end
				yppc_pkg::REG_GAIN_INTEG: begin
					cfg_q.gain_integ <= pwdata[yppc_pkg::GAIN_W-1:0];
				end
				yppc_pkg::REG_GAIN_DERIV: begin
					cfg_q.gain_deriv <= pwdata[yppc_pkg::GAIN_W-1:0];
				end
				yppc_pkg::REG_ERR_LIMIT: begin
					cfg_q.error_limit <= pwdata[yppc_pkg::LIM_W-1:0];
				end
				yppc_pkg::REG_STEP_LIMIT: begin
					cfg_q.integral_step_limit <= pwdata[yppc_pkg::LIM_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Read data, zero-extended to the bus width.
	always_comb begin
		unique case (idx)
			yppc_pkg::REG_GAIN_PROP:  prdata = yppc_pkg::DATA_W'(cfg_q.gain_prop);
			yppc_pkg::REG_GAIN_INTEG: prdata = yppc_pkg::DATA_W'(cfg_q.gain_integ);
			yppc_pkg::REG_GAIN_DERIV: prdata = yppc_pkg::DATA_W'(cfg_q.gain_deriv);
			yppc_pkg::REG_ERR_LIMIT:  prdata = yppc_pkg::DATA_W'(cfg_q.error_limit);
			yppc_pkg::REG_STEP_LIMIT: prdata = yppc_pkg::DATA_W'(cfg_q.integral_step_limit);
			default:                  prdata = '0;
		endcase
	end

endmodule

### rtl/yppc_err.sv
// Input register and error stage: difference, half-turn wrap and both clamps.
// Depends on yppc_pkg.
module yppc_err (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 adv,
	input  logic                                 in_valid,
	input  logic                                 position_mode,
	input  logic signed [yppc_pkg::ANG_W-1:0]    target_yaw,
	input  logic signed [yppc_pkg::ANG_W-1:0]    measured_yaw,
	input  yppc_pkg::cfg_t                       cfg,
	output yppc_pkg::err_stage_t                 s2
);

	yppc_pkg::in_stage_t                 in_s1;
	yppc_pkg::err_stage_t                err_s2;
	logic signed [yppc_pkg::ERR_W-1:0]   diff;
	logic signed [yppc_pkg::ERR_W-1:0]   wrapped;
	logic signed [yppc_pkg::ERR_W-1:0]   err_c;
	logic signed [yppc_pkg::ERR_W-1:0]   step_c;

	// Input register; a transaction enters whenever the pipeline advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_s1 <= '0;
		end else if (adv) begin
			in_s1.valid    <= in_valid;
			in_s1.mode     <= position_mode;
			in_s1.target   <= target_yaw;
			in_s1.measured <= measured_yaw;
		end
	end

	// Error, wrapped once into half a turn, then clamped twice.
	always_comb begin
		diff = {in_s1.target[yppc_pkg::ANG_W-1], in_s1.target}
			- {in_s1.measured[yppc_pkg::ANG_W-1], in_s1.measured};
		if (diff > yppc_pkg::HALF_TURN) begin
			wrapped = diff - yppc_pkg::FULL_TURN;
		end else if (diff < -yppc_pkg::HALF_TURN) begin
			wrapped = diff + yppc_pkg::FULL_TURN;
		end else begin
			wrapped = diff;
		end
		err_c  = yppc_pkg::clamp_sym(wrapped, cfg.error_limit);
		step_c = yppc_pkg::clamp_sym(err_c, cfg.integral_step_limit);
	end

	// Stage two register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_s2 <= '0;
		end else if (adv) begin
			err_s2.valid <= in_s1.valid;
			err_s2.mode  <= in_s1.mode;
			err_s2.err   <= err_c;
			err_s2.step  <= step_c;
		end
	end

	assign s2 = err_s2;

endmodule

### rtl/yppc_integ.sv
// Controller state: saturating error integral and previous error, plus the
// derivative term. Depends on yppc_pkg.
module yppc_integ (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  yppc_pkg::err_stage_t  s2,
	output yppc_pkg::pid_stage_t  s3
);

	logic signed [yppc_pkg::INT_W-1:0] integ_q;
	logic signed [yppc_pkg::ERR_W-1:0] prev_q;
	yppc_pkg::pid_stage_t              pid_s3;
	logic signed [yppc_pkg::INT_W:0]   integ_sum;
	logic signed [yppc_pkg::INT_W-1:0] integ_sat;
	logic signed [yppc_pkg::DE_W-1:0]  de_c;
	logic                              run;

	assign run = s2.valid && s2.mode;

	// Integral step with saturation at the integral width, and the derivative.
	always_comb begin
		integ_sum = {integ_q[yppc_pkg::INT_W-1], integ_q}
			+ (yppc_pkg::INT_W + 1)'(s2.step);
		if (integ_sum[yppc_pkg::INT_W] != integ_sum[yppc_pkg::INT_W-1]) begin
			integ_sat = integ_sum[yppc_pkg::INT_W]
				? {1'b1, {(yppc_pkg::INT_W - 1){1'b0}}}
				: {1'b0, {(yppc_pkg::INT_W - 1){1'b1}}};
		end else begin
			integ_sat = integ_sum[yppc_pkg::INT_W-1:0];
		end
		de_c = {s2.err[yppc_pkg::ERR_W-1], s2.err} - {prev_q[yppc_pkg::ERR_W-1], prev_q};
	end

	// State update: a run transaction accumulates, a hold transaction clears.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			prev_q  <= '0;
		end else if (adv && s2.valid) begin
			if (s2.mode) begin
				integ_q <= integ_sat;
				prev_q  <= s2.err;
			end else begin
				integ_q <= '0;
				prev_q  <= '0;
			end
		end
	end

	// Stage three register; hold transactions leave the pipeline here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid_s3 <= '0;
		end else if (adv) begin
			pid_s3.valid <= run;
			pid_s3.err   <= s2.err;
			pid_s3.de    <= de_c;
			pid_s3.integ <= integ_sat;
		end
	end

	assign s3 = pid_s3;

endmodule

### rtl/yppc_mac.sv
// Gain products, rounded sum, output saturation and the output register.
// Depends on yppc_pkg.
module yppc_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  yppc_pkg::pid_stage_t                s3,
	input  yppc_pkg::cfg_t                      cfg,
	input  logic                                out_stall,
	output logic                                adv,
	output logic                                out_valid,
	output logic signed [yppc_pkg::OUT_W-1:0]   speed_command
);

	yppc_pkg::prod_stage_t               prod_s4;
	logic                                out_valid_q;
	logic signed [yppc_pkg::OUT_W-1:0]   speed_q;
	logic signed [yppc_pkg::P_E_W-1:0]   p_e_c;
	logic signed [yppc_pkg::P_DE_W-1:0]  p_de_c;
	logic signed [yppc_pkg::P_I_W-1:0]   p_i_c;
	logic signed [yppc_pkg::SUM_W-1:0]   sum_c;
	logic signed [yppc_pkg::SUM_W-1:0]   neg_c;
	logic signed [yppc_pkg::QUO_W-1:0]   quo_c;
	logic signed [yppc_pkg::OUT_W-1:0]   sat_c;

	// The pipeline moves unless a finished result is held by the receiver.
	assign adv = !(out_valid_q && out_stall);

	// Three products of the Q2.16 gains with the error terms.
	always_comb begin
		p_e_c  = $signed({1'b0, cfg.gain_prop}) * s3.err;
		p_de_c = $signed({1'b0, cfg.gain_deriv}) * s3.de;
		p_i_c  = $signed({1'b0, cfg.gain_integ}) * s3.integ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_s4 <= '0;
		end else if (adv) begin
			prod_s4.valid <= s3.valid;
			prod_s4.p_e   <= p_e_c;
			prod_s4.p_de  <= p_de_c;
			prod_s4.p_i   <= p_i_c;
		end
	end

	// Negated sum, rounded half up to an integer, then saturated.
	always_comb begin
		sum_c = yppc_pkg::SUM_W'(prod_s4.p_e) + yppc_pkg::SUM_W'(prod_s4.p_de)
			+ yppc_pkg::SUM_W'(prod_s4.p_i);
		neg_c = yppc_pkg::ROUND_HALF - sum_c;
		quo_c = neg_c[yppc_pkg::SUM_W-1:yppc_pkg::FRAC_W];
		if (quo_c > yppc_pkg::OUT_MAX) begin
			sat_c = yppc_pkg::OUT_MAX[yppc_pkg::OUT_W-1:0];
		end else if (quo_c < yppc_pkg::OUT_MIN) begin
			sat_c = yppc_pkg::OUT_MIN[yppc_pkg::OUT_W-1:0];
		end else begin
			sat_c = quo_c[yppc_pkg::OUT_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			speed_q     <= '0;
		end else if (adv) begin
			out_valid_q <= prod_s4.valid;
			speed_q     <= sat_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign speed_command = speed_q;

endmodule

### sim/tb_yaw_pid_position_controller_top.sv
// Self-checking testbench of the yaw PID position controller top level.
// Depends on yppc_pkg and the RTL only; it predicts each speed command itself
// and compares it with the block's output, under random idling on both sides.
module tb_yaw_pid_position_controller_top;

	localparam int QUEUE_DEPTH = 64;
	localparam int DRAIN_CYCLES = 12;
	localparam int HOLD_AFTER = 120;
	localparam int HOLD_CYCLES = 200;
	localparam int SAT_STEPS = 12;
	localparam int TURN_BACK = 6;
	localparam longint INTEG_MAX = 64'sd2147483647;
	localparam longint INTEG_MIN = -64'sd2147483648;
	localparam logic [yppc_pkg::IDX_W-1:0] REG_SPARE = 3'd5;
	localparam logic [yppc_pkg::DATA_W-1:0] GAIN_FULL = 32'h0003_FFFF;
	localparam logic [yppc_pkg::DATA_W-1:0] LIMIT_FULL = 32'h0000_3FFF;

	typedef struct packed {
		logic                              mode;
		logic signed [yppc_pkg::ANG_W-1:0] target;
		logic signed [yppc_pkg::ANG_W-1:0] measured;
	} yaw_sample_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [yppc_pkg::ADDR_W-1:0] paddr = '0;
	logic [yppc_pkg::DATA_W-1:0] pwdata = '0;
	logic [yppc_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic position_mode = 1'b0;
	logic signed [yppc_pkg::ANG_W-1:0] target_yaw = '0;
	logic signed [yppc_pkg::ANG_W-1:0] measured_yaw = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [yppc_pkg::OUT_W-1:0] speed_command;

	// Register copies, loop state and the transaction stores.
	logic [yppc_pkg::GAIN_W-1:0] kp_gain = yppc_pkg::RST_GAIN_PROP;
	logic [yppc_pkg::GAIN_W-1:0] ki_gain = yppc_pkg::RST_GAIN_INTEG;
	logic [yppc_pkg::GAIN_W-1:0] kd_gain = yppc_pkg::RST_GAIN_DERIV;
	logic [yppc_pkg::LIM_W-1:0] err_lim = yppc_pkg::RST_ERR_LIMIT;
	logic [yppc_pkg::LIM_W-1:0] step_lim = yppc_pkg::RST_STEP_LIMIT;
	int last_err = 0;
	int integ_sum = 0;
	yaw_sample_t yaw_pending[$];
	logic signed [yppc_pkg::OUT_W-1:0] cmd_expected[$];
	logic signed [yppc_pkg::OUT_W-1:0] cmd_want;
	yaw_sample_t upcoming;
	logic in_fire = 1'b0;
	logic out_fire = 1'b0;
	bit fast_mode = 1'b0;
	bit hold_done = 1'b0;
	int tx_gap = 0;
	int tx_calm = 0;
	int rx_wait = 0;
	int rx_calm = 0;
	int results_seen = 0;
	int mismatches = 0;

	yaw_pid_position_controller_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.position_mode(position_mode),
		.target_yaw(target_yaw),
		.measured_yaw(measured_yaw),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.speed_command(speed_command)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Symmetric clamp of a signed value to plus or minus a limit.
	function automatic int bound_sym(input int v, input int lim);
		if (v > lim) return lim;
		if (v < -lim) return -lim;
		return v;
	endfunction

	// Wait drawn per transaction, with occasional stretches of no waiting.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 9) == 0) begin
			calm = int'($urandom_range(10, 40));
			return 0;
		end
		return int'($urandom_range(0, 14));
	endfunction

	function automatic yaw_sample_t yaw_item(input bit m, input int t, input int ms);
		yaw_sample_t s;
		s.mode = m;
		s.target = yppc_pkg::ANG_W'(t);
		s.measured = yppc_pkg::ANG_W'(ms);
		return s;
	endfunction

	// Mostly angles within half a turn, some at the wrap boundary, some anywhere.
	function automatic logic signed [yppc_pkg::ANG_W-1:0] pick_angle();
		int r;
		int v;
		r = int'($urandom_range(0, 19));
		if (r == 0) begin
			v = int'($urandom_range(0, 32767));
		end else if (r == 1) begin
			v = int'($urandom_range(11518, 11522));
			if ($urandom_range(0, 1) == 1) v = -v;
		end else begin
			v = int'($urandom_range(0, 23040)) - 11520;
		end
		return yppc_pkg::ANG_W'(v);
	endfunction

	// Advance the control loop by one accepted transaction and record the
	// speed command it produces, if any.
	task automatic advance_loop(input yaw_sample_t s);
		int diff;
		int err;
		int step_err;
		longint acc;
		longint total;
		longint q;
		if (!s.mode) begin
			last_err = 0;
			integ_sum = 0;
		end else begin
			diff = int'($signed(s.target)) - int'($signed(s.measured));
			if (diff > int'(yppc_pkg::HALF_TURN)) begin
				diff -= int'(yppc_pkg::FULL_TURN);
			end else if (diff < -int'(yppc_pkg::HALF_TURN)) begin
				diff += int'(yppc_pkg::FULL_TURN);
			end
			err = bound_sym(diff, int'(err_lim));
			step_err = bound_sym(err, int'(step_lim));
			acc = longint'(integ_sum) + step_err;
			if (acc > INTEG_MAX) acc = INTEG_MAX;
			if (acc < INTEG_MIN) acc = INTEG_MIN;
			integ_sum = int'(acc);
			total = longint'(kp_gain) * err + longint'(kd_gain) * (err - last_err)
				+ longint'(ki_gain) * acc;
			// Arithmetic shift gives the floor, so ties round upwards.
			q = (-total + 64'sd32768) >>> yppc_pkg::FRAC_W;
			if (q > 64'sd32767) q = 64'sd32767;
			if (q < -64'sd32768) q = -64'sd32768;
			last_err = err;
			cmd_expected.push_back(yppc_pkg::OUT_W'(q));
		end
	endtask

	// Sampling at the rising edge: predict on input transactions, check outputs.
	always @(posedge clk) begin
		in_fire <= arst_n && in_valid && !in_stall;
		out_fire <= arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (cmd_expected.size() == 0) begin
				$error("speed_command: unexpected result, actual %0d", speed_command);
				mismatches++;
			end else begin
				cmd_want = cmd_expected.pop_front();
				if (speed_command !== cmd_want) begin
					$error("speed_command: expected %0d, actual %0d", cmd_want,
						speed_command);
					mismatches++;
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			advance_loop({position_mode, target_yaw, measured_yaw});
		end
	end

	// Input driver: one transaction from the pending queue, then a drawn gap.
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else if (!in_valid || in_fire) begin
			if (tx_gap > 0) begin
				tx_gap--;
				in_valid <= 1'b0;
			end else if (yaw_pending.size() != 0) begin
				upcoming = yaw_pending.pop_front();
				position_mode <= upcoming.mode;
				target_yaw <= upcoming.target;
				measured_yaw <= upcoming.measured;
				in_valid <= 1'b1;
				tx_gap = fast_mode ? 0 : draw_wait(tx_calm);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: a drawn stall, possibly none, after each transaction, and
	// once a long stretch so that the pipeline fills and pushes back on the input.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
		end else begin
			if (!hold_done && results_seen >= HOLD_AFTER) begin
				hold_done = 1'b1;
				rx_wait = HOLD_CYCLES;
			end else if (out_fire) begin
				rx_wait = fast_mode ? 0 : draw_wait(rx_calm);
			end
			if (rx_wait > 0) begin
				out_stall <= 1'b1;
				rx_wait--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic offer(input yaw_sample_t s);
		while (yaw_pending.size() >= QUEUE_DEPTH) @(posedge clk);
		yaw_pending.push_back(s);
	endtask

	// Wait until every transaction is through, then let the pipeline empty.
	task automatic drain();
		while (yaw_pending.size() != 0 || in_valid || cmd_expected.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [yppc_pkg::IDX_W-1:0] idx,
		input logic [yppc_pkg::DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			yppc_pkg::REG_GAIN_PROP: kp_gain = value[yppc_pkg::GAIN_W-1:0];
			yppc_pkg::REG_GAIN_INTEG: ki_gain = value[yppc_pkg::GAIN_W-1:0];
			yppc_pkg::REG_GAIN_DERIV: kd_gain = value[yppc_pkg::GAIN_W-1:0];
			yppc_pkg::REG_ERR_LIMIT: err_lim = value[yppc_pkg::LIM_W-1:0];
			yppc_pkg::REG_STEP_LIMIT: step_lim = value[yppc_pkg::LIM_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic load_gains(input logic [yppc_pkg::DATA_W-1:0] kp,
		input logic [yppc_pkg::DATA_W-1:0] ki, input logic [yppc_pkg::DATA_W-1:0] kd,
		input logic [yppc_pkg::DATA_W-1:0] el, input logic [yppc_pkg::DATA_W-1:0] sl);
		write_reg(yppc_pkg::REG_GAIN_PROP, kp);
		write_reg(yppc_pkg::REG_GAIN_INTEG, ki);
		write_reg(yppc_pkg::REG_GAIN_DERIV, kd);
		write_reg(yppc_pkg::REG_ERR_LIMIT, el);
		write_reg(yppc_pkg::REG_STEP_LIMIT, sl);
	endtask

	// Runs of tracking transactions, where the measured yaw closes in on the
	// target, mixed with independent samples and mode noise.
	task automatic random_phase(input int count);
		int left;
		int kind;
		int run_len;
		int aim;
		int pos;
		left = count;
		while (left > 0) begin
			kind = int'($urandom_range(0, 9));
			run_len = int'($urandom_range(4, 24));
			if (run_len > left) run_len = left;
			aim = int'(pick_angle());
			pos = int'(pick_angle());
			for (int k = 0; k < run_len; k++) begin
				if (kind < 6) begin
					if (k == 0 && $urandom_range(0, 2) == 0) begin
						offer(yaw_item(1'b0, aim, pos));
					end else begin
						pos = int'(yppc_pkg::ANG_W'(pos + (aim - pos) / 4
							+ int'($urandom_range(0, 128)) - 64));
						offer(yaw_item(1'b1, aim, pos));
					end
				end else if (kind < 9) begin
					offer(yaw_item($urandom_range(0, 5) != 0, pick_angle(), pick_angle()));
				end else begin
					offer(yaw_item(1'($urandom_range(0, 1)), int'($urandom_range(0, 32767)),
						int'($urandom_range(0, 32767))));
				end
			end
			left -= run_len;
		end
	endtask

	initial begin
		#2000000;
		$display("tb_yaw_pid_position_controller_top failed");
		$finish;
	end

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed transactions under the reset configuration.
		offer(yaw_item(1'b1, 0, 0));
		offer(yaw_item(1'b1, 64, 0));
		offer(yaw_item(1'b1, -64, 0));
		offer(yaw_item(1'b1, 11520, 0));
		offer(yaw_item(1'b1, 11520, -11520));
		offer(yaw_item(1'b1, -11520, 11520));
		offer(yaw_item(1'b1, 100, -11421));
		offer(yaw_item(1'b1, -100, 11421));
		offer(yaw_item(1'b1, 16383, -16384));
		offer(yaw_item(1'b1, -16384, 16383));
		offer(yaw_item(1'b1, 5761, 0));
		offer(yaw_item(1'b0, -16384, 16383));
		offer(yaw_item(1'b1, 1920, 0));
		offer(yaw_item(1'b1, 1921, 0));
		offer(yaw_item(1'b0, 16383, -16384));
		offer(yaw_item(1'b0, 0, 0));
		offer(yaw_item(1'b1, -11520, 0));
		offer(yaw_item(1'b1, 11519, -1));
		offer(yaw_item(1'b1, -11519, 1));
		offer(yaw_item(1'b1, -1, -1));
		random_phase(120);

		// Every register at its maximum, then at zero.
		drain();
		load_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL, LIMIT_FULL, LIMIT_FULL);
		random_phase(80);
		drain();
		load_gains('0, '0, '0, '0, '0);
		random_phase(60);

		// Unmasked random words, and a write to an unused register index.
		drain();
		load_gains($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
		write_reg(REG_SPARE, $urandom());
		random_phase(100);

		// Gains and limits of the sizes met in service.
		for (int p = 0; p < 4; p++) begin
			drain();
			load_gains($urandom_range(0, 65536), $urandom_range(0, 2000),
				$urandom_range(0, 20000), $urandom_range(0, 11520),
				$urandom_range(0, 11520));
			random_phase(90);
		end

		// Back-to-back runs of the largest error in each direction with the
		// full integral gain drive the command into saturation; a shorter run
		// the other way then winds the integral back, the command still saturated.
		drain();
		fast_mode = 1'b1;
		load_gains('0, GAIN_FULL, '0, LIMIT_FULL, LIMIT_FULL);
		for (int sgn = 0; sgn < 2; sgn++) begin
			offer(yaw_item(1'b0, 0, 0));
			for (int k = 0; k < SAT_STEPS; k++) begin
				offer(yaw_item(1'b1, (sgn == 0) ? 11520 : -11520, 0));
			end
			for (int k = 0; k < TURN_BACK; k++) begin
				offer(yaw_item(1'b1, (sgn == 0) ? -11520 : 11520, 0));
			end
		end
		drain();
		fast_mode = 1'b0;

		if (mismatches == 0) begin
			$display("tb_yaw_pid_position_controller_top passed");
		end else begin
			$display("tb_yaw_pid_position_controller_top failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/yppc_pkg.sv
rtl/yppc_cfg.sv
rtl/yppc_err.sv
rtl/yppc_integ.sv
rtl/yppc_mac.sv
rtl/yaw_pid_position_controller_top.sv
sim/tb_yaw_pid_position_controller_top.sv
